// File: hw/rtl/rcu_pkg.sv
// ----------------------------------------------------------------------------
// rcu_pkg
// Types, constants and small calendar tables for the rtc calendar to
// unix time converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rcu_pkg;

  // register indexes on the configuration port
  localparam logic REG_PRESCALER = 1'b0;

  localparam logic [14:0] PRESCALER_RESET = 15'd255;

  // quotient bits of the fraction divider, one per pipeline stage
  localparam int DIV_STEPS = 30;
  // decode, day count, seconds stages ahead of the divider
  localparam int FRONT_STAGES = 3;
  localparam int NUM_STAGES = FRONT_STAGES + DIV_STEPS;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [33:0] SEC_PER_DAY = 34'd86400;

  localparam int DAYS_PER_ERA = 146097;
  localparam int EPOCH_SHIFT = 719468;
  // era base minus the 1970 shift, for the two eras that year offsets 0 to 127 reach
  localparam logic [17:0] ERA4_OFS = 18'(4 * DAYS_PER_ERA - EPOCH_SHIFT);
  localparam logic [17:0] ERA5_OFS = 18'(5 * DAYS_PER_ERA - EPOCH_SHIFT);

  // year 2100 is the only non-leap year divisible by four in range
  localparam logic [6:0] CENTURY_YOFF = 7'd100;

  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [4:0] HOUR_MAX = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;

  typedef struct packed {
    logic [6:0]  year_offset;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_value;
    logic [5:0]  minute_value;
    logic [5:0]  second_value;
    logic [15:0] subsecond_count;
  } rcu_in_t;

  typedef struct packed {
    logic        status;
    logic [31:0] epoch_seconds;
    logic [29:0] fraction_nanoseconds;
  } rcu_out_t;

  function automatic logic [4:0] month_days_f(logic [3:0] m, logic leap);
    logic [4:0] r;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:                                      r = leap ? 5'd29 : 5'd28;
      default:                                   r = 5'd0;
    endcase
    return r;
  endfunction

  // first day of month within a march-based year, (153*mp+2)/5
  function automatic logic [8:0] march_doy_f(logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rtc_calendar_to_unix_time.sv
// ----------------------------------------------------------------------------
// rtc_calendar_to_unix_time
// Checks an rtc calendar reading and converts it to unix seconds plus
// nanoseconds within the second.
// ----------------------------------------------------------------------------
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------
//   in       | in_valid / in_ready    | in_data  (rcu_in_t)
//   out      | out_valid / out_ready  | out_data (rcu_out_t)
//   config   | psel penable pwrite    | paddr pwdata prdata, pready = 1
//
// One transaction enters per cycle while the pipeline is not full and stalled:
// three stages for decode, day count and seconds, then 30 stages of a
// bit-per-stage restoring divider by prescaler + 1 for the fraction.
// Reset (synchronous, rst_n low) empties the pipeline and sets the
// prescaler to 255. Each stage holds its transaction while the one after it
// is full and stalled, so bubbles close up and out_ready low stops nothing
// until the whole pipeline is full.
//
`default_nettype none

module rtc_calendar_to_unix_time
  import rcu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire rcu_in_t     in_data,

  output logic             out_valid,
  input  wire logic        out_ready,
  output rcu_out_t         out_data,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration
  logic [14:0] presc_r;
  logic [15:0] dvsr;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PRESCALER) ? 32'(presc_r) : '0;
  assign dvsr   = 16'(presc_r) + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r <= PRESCALER_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PRESCALER) begin
      presc_r <= pwdata[14:0];
    end
  end

  // pipeline flow control
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES:0]   adv;

  always_comb begin
    adv[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = ~vld_r[k] | adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage a: validation and calendar decode
  logic       leap_a;
  logic [4:0] mdays_a;
  logic       err_nxt_a;
  logic       early_a;
  logic       wrap_a;
  logic [3:0] mp_a;
  logic [8:0] doy_nxt_a;
  logic [8:0] yoe_nxt_a;
  logic [14:0] diff_nxt_a;

  always_comb begin
    leap_a  = (in_data.year_offset[1:0] == 2'b00) && (in_data.year_offset != CENTURY_YOFF);
    mdays_a = month_days_f(in_data.month_number, leap_a);
    err_nxt_a = (in_data.month_number == 4'd0) || (in_data.month_number > MONTH_MAX) ||
                (in_data.day_of_month == 5'd0) || (in_data.day_of_month > mdays_a) ||
                (in_data.hour_value > HOUR_MAX) || (in_data.minute_value > MINSEC_MAX) ||
                (in_data.second_value > MINSEC_MAX) ||
                (in_data.subsecond_count > 16'(presc_r));
    // january and february belong to the previous march-based year
    early_a = (in_data.month_number <= 4'd2);
    mp_a    = early_a ? in_data.month_number + 4'd9 : in_data.month_number - 4'd3;
    doy_nxt_a = march_doy_f(mp_a) + 9'(in_data.day_of_month) - 9'd1;
    // jan/feb 2000 fall in the era that starts in 1600
    wrap_a    = early_a && (in_data.year_offset == 7'd0);
    yoe_nxt_a = wrap_a ? 9'd399 : 9'(in_data.year_offset) - 9'(early_a);
    diff_nxt_a = presc_r - in_data.subsecond_count[14:0];
  end

  logic        err_a_r;
  logic [14:0] diff_a_r;
  logic [8:0]  doy_a_r;
  logic [8:0]  yoe_a_r;
  logic        era5_a_r;
  logic [4:0]  hr_a_r;
  logic [5:0]  mi_a_r;
  logic [5:0]  se_a_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      err_a_r  <= err_nxt_a;
      diff_a_r <= diff_nxt_a;
      doy_a_r  <= doy_nxt_a;
      yoe_a_r  <= yoe_nxt_a;
      era5_a_r <= ~wrap_a;
      hr_a_r   <= in_data.hour_value;
      mi_a_r   <= in_data.minute_value;
      se_a_r   <= in_data.second_value;
    end
  end

  // stage b: fraction numerator, day number, time of day
  logic [1:0]  cent_b;
  logic [17:0] doe_b;
  logic [16:0] days_nxt_b;
  logic [16:0] hms_nxt_b;
  logic [44:0] prod_nxt_b;

  always_comb begin
    if (yoe_a_r >= 9'd300) begin
      cent_b = 2'd3;
    end else if (yoe_a_r >= 9'd200) begin
      cent_b = 2'd2;
    end else if (yoe_a_r >= 9'd100) begin
      cent_b = 2'd1;
    end else begin
      cent_b = 2'd0;
    end
    doe_b = 18'(yoe_a_r) * 18'd365 + 18'(yoe_a_r[8:2]) - 18'(cent_b) + 18'(doy_a_r);
    days_nxt_b = 17'(doe_b + (era5_a_r ? ERA5_OFS : ERA4_OFS));
    hms_nxt_b  = 17'(hr_a_r) * 17'd3600 + 17'(mi_a_r) * 17'd60 + 17'(se_a_r);
    prod_nxt_b = 45'(diff_a_r) * 45'(NS_PER_SEC);
  end

  logic        err_b_r;
  logic [16:0] days_b_r;
  logic [16:0] hms_b_r;
  logic [44:0] prod_b_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      err_b_r  <= err_a_r;
      days_b_r <= days_nxt_b;
      hms_b_r  <= hms_nxt_b;
      prod_b_r <= prod_nxt_b;
    end
  end

  // stage c: epoch seconds, divider load; an invalid reading is zeroed here
  logic [33:0] dsec_c;
  logic [31:0] sec_nxt_c;
  logic [44:0] num_nxt_c;

  always_comb begin
    dsec_c    = 34'(days_b_r) * SEC_PER_DAY;
    sec_nxt_c = err_b_r ? '0 : dsec_c[31:0] + 32'(hms_b_r);
    num_nxt_c = err_b_r ? '0 : prod_b_r;
  end

  logic [14:0]          rem_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] nq_r  [DIV_STEPS+1];
  logic [31:0]          sec_r [DIV_STEPS+1];
  logic                 err_r [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      rem_r[0] <= num_nxt_c[44:DIV_STEPS];
      nq_r[0]  <= num_nxt_c[DIV_STEPS-1:0];
      sec_r[0] <= sec_nxt_c;
      err_r[0] <= err_b_r;
    end
  end

  // divider stages: numerator bits shift out the top as quotient bits enter
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [15:0]          trial;
    logic                 ge;
    logic [14:0]          rem_nxt;
    logic [DIV_STEPS-1:0] nq_nxt;

    assign trial   = {rem_r[k], nq_r[k][DIV_STEPS-1]};
    assign ge      = (trial >= dvsr);
    assign rem_nxt = ge ? 15'(trial - dvsr) : trial[14:0];
    assign nq_nxt  = {nq_r[k][DIV_STEPS-2:0], ge};

    always_ff @(posedge clk) begin
      if (adv[FRONT_STAGES+k]) begin
        rem_r[k+1] <= rem_nxt;
        nq_r[k+1]  <= nq_nxt;
        sec_r[k+1] <= sec_r[k];
        err_r[k+1] <= err_r[k];
      end
    end
  end

  assign out_valid = vld_r[NUM_STAGES-1];

  always_comb begin
    out_data.status               = err_r[DIV_STEPS];
    out_data.epoch_seconds        = sec_r[DIV_STEPS];
    out_data.fraction_nanoseconds = nq_r[DIV_STEPS];
  end

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |->
      out_data.epoch_seconds == 32'd0 && out_data.fraction_nanoseconds == 30'd0)
    else $error("error result carries nonzero values");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fraction_nanoseconds < NS_PER_SEC)
    else $error("fraction at or above one second");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off while the output is not stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

endmodule

`default_nettype wire

// File: tb/tb_rtc_calendar_to_unix_time.sv
// ----------------------------------------------------------------------------
// tb_rtc_calendar_to_unix_time
// Self-checking bench for the rtc calendar to unix time converter. Readings
// are fed through a valid/ready driver. A clocked monitor predicts each
// accepted transaction and compares every result, field by field, in order.
// The prescaler is reprogrammed between drained phases over the apb port.
// ----------------------------------------------------------------------------
module tb_rtc_calendar_to_unix_time;
  import rcu_pkg::*;

  localparam int unsigned BASE_YEAR = 2000;
  localparam logic [2:0] ADDR_PRESCALER = 3'(4 * REG_PRESCALER);
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = NUM_STAGES + 8;
  localparam int IDLE_PCT = 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  rcu_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rcu_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rcu_in_t     readings_to_send[$];
  rcu_out_t    expected_stamps[$];
  logic [14:0] prescaler_cfg = PRESCALER_RESET;
  logic        in_taken = 1'b0;
  logic        steady = 1'b0;
  int          queued_count = 0;
  int          results_seen = 0;
  int          mismatch_count = 0;
  int          idle_cycles = 0;

  rtc_calendar_to_unix_time dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned month_len_days(int unsigned year, logic [3:0] m);
    logic leap;
    leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    case (m)
      4'd2:                                      return leap ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11:                   return 30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
      default:                                   return 0;
    endcase
  endfunction

  function automatic rcu_out_t predict_timestamp(rcu_in_t r, logic [14:0] pre);
    int unsigned year, yy, era, yoe, mp, doy, doe;
    longint unsigned days, secs, nanos, pre_l, sub_l;
    rcu_out_t res;
    res = '0;
    year = BASE_YEAR + r.year_offset;
    if (r.month_number == 0 || r.month_number > MONTH_MAX || r.day_of_month == 0 ||
        r.day_of_month > month_len_days(year, r.month_number) ||
        r.hour_value > HOUR_MAX || r.minute_value > MINSEC_MAX ||
        r.second_value > MINSEC_MAX || r.subsecond_count > pre) begin
      res.status = 1'b1;
      return res;
    end
    // days from civil, march-based year
    yy = (r.month_number <= 2) ? year - 1 : year;
    era = yy / 400;
    yoe = yy - era * 400;
    mp = (r.month_number > 2) ? r.month_number - 3 : r.month_number + 9;
    doy = (153 * mp + 2) / 5 + r.day_of_month - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = longint'(era) * DAYS_PER_ERA + doe - EPOCH_SHIFT;
    secs = days * SEC_PER_DAY + longint'(r.hour_value) * 3600 +
           longint'(r.minute_value) * 60 + r.second_value;
    pre_l = 64'(pre);
    sub_l = 64'(r.subsecond_count);
    nanos = (pre_l - sub_l) * NS_PER_SEC / (pre_l + 1);
    res.epoch_seconds = secs[31:0];
    res.fraction_nanoseconds = nanos[29:0];
    return res;
  endfunction

  function automatic rcu_in_t reading(int yoff, int mon, int day, int hr, int mi, int se,
                                      int sub);
    rcu_in_t r;
    r.year_offset = 7'(yoff);
    r.month_number = 4'(mon);
    r.day_of_month = 5'(day);
    r.hour_value = 5'(hr);
    r.minute_value = 6'(mi);
    r.second_value = 6'(se);
    r.subsecond_count = 16'(sub);
    return r;
  endfunction

  function automatic rcu_in_t valid_reading(logic [14:0] pre);
    int yoff, mon, sub;
    yoff = ($urandom_range(9) == 0) ? $urandom_range(127, 100) : $urandom_range(99);
    mon = $urandom_range(12, 1);
    case ($urandom_range(3))
      0:       sub = 0;
      1:       sub = int'(pre);
      default: sub = $urandom_range(pre);
    endcase
    return reading(yoff, mon, $urandom_range(month_len_days(BASE_YEAR + yoff, mon), 1),
                   $urandom_range(23), $urandom_range(59), $urandom_range(59), sub);
  endfunction

  function automatic rcu_in_t random_reading(logic [14:0] pre);
    rcu_in_t r;
    int unsigned pick, len;
    pick = $urandom_range(99);
    r = valid_reading(pre);
    if (pick >= 85) begin
      r = rcu_in_t'({$urandom, $urandom});
    end else if (pick >= 70) begin
      // one field pushed out of range
      len = month_len_days(BASE_YEAR + r.year_offset, r.month_number);
      case ($urandom_range(5))
        0: r.month_number = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(15, 13));
        1: r.day_of_month = (len == 31 || $urandom_range(3) == 0) ? 5'd0 :
                            5'($urandom_range(31, len + 1));
        2: r.hour_value = 5'($urandom_range(31, 24));
        3: r.minute_value = 6'($urandom_range(63, 60));
        4: r.second_value = 6'($urandom_range(63, 60));
        default: r.subsecond_count = 16'($urandom_range(65535, pre + 1));
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send(rcu_in_t r);
    readings_to_send.push_back(r);
    queued_count++;
  endtask

  task automatic send_random(int count);
    repeat (count) send(random_reading(prescaler_cfg));
  endtask

  // subsecond at both ends of the valid range, just past it and at the field maximum
  task automatic send_subsecond_edges();
    rcu_in_t r;
    r = valid_reading(prescaler_cfg);
    r.subsecond_count = '0;
    send(r);
    r.subsecond_count = 16'(prescaler_cfg);
    send(r);
    r.subsecond_count = 16'(prescaler_cfg) + 16'd1;
    send(r);
    r.subsecond_count = 16'hFFFF;
    send(r);
  endtask

  task automatic wait_drained();
    while (results_seen < queued_count) @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_PRESCALER) prescaler_cfg = data[14:0];
  endtask

  task automatic check_prescaler_readback();
    logic [31:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= ADDR_PRESCALER;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== {17'b0, prescaler_cfg})
      report_mismatch($sformatf("prescaler read %0h want %0h", rd, prescaler_cfg));
  endtask

  task automatic program_prescaler(logic [14:0] value);
    apb_write(ADDR_PRESCALER, {17'($urandom), value});
    check_prescaler_readback();
  endtask

  // driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (readings_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_data <= readings_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    rcu_out_t want;
    in_taken <= in_valid && in_ready;
    if (in_valid && in_ready)
      expected_stamps.push_back(predict_timestamp(in_data, prescaler_cfg));
    if (out_valid && out_ready) begin
      results_seen++;
      if (expected_stamps.size() == 0) begin
        report_mismatch("result with no conversion pending");
      end else begin
        want = expected_stamps.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0b want %0b", out_data.status, want.status));
        if (out_data.epoch_seconds !== want.epoch_seconds)
          report_mismatch($sformatf("epoch_seconds %0d want %0d",
                                    out_data.epoch_seconds, want.epoch_seconds));
        if (out_data.fraction_nanoseconds !== want.fraction_nanoseconds)
          report_mismatch($sformatf("fraction_nanoseconds %0d want %0d",
                                    out_data.fraction_nanoseconds,
                                    want.fraction_nanoseconds));
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb_rtc_calendar_to_unix_time: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    // prescaler must come out of reset at its default
    check_prescaler_readback();

    send(reading(0, 1, 1, 0, 0, 0, 255));
    send(reading(0, 1, 1, 0, 0, 0, 0));
    send(reading(99, 12, 31, 23, 59, 59, 128));
    send(reading(0, 2, 29, 12, 30, 30, 1));       // 2000 is a leap year
    send(reading(1, 2, 29, 12, 30, 30, 1));
    send(reading(100, 2, 29, 0, 0, 0, 0));        // 2100 is not
    send(reading(100, 2, 28, 23, 59, 59, 0));
    send(reading(104, 2, 29, 1, 2, 3, 4));
    send(reading(106, 2, 7, 6, 28, 15, 0));       // last second below 2^32
    send(reading(106, 2, 7, 6, 28, 16, 0));       // seconds wrap
    send(reading(127, 12, 31, 23, 59, 59, 0));
    send(reading(0, 0, 1, 0, 0, 0, 0));
    send(reading(5, 13, 1, 0, 0, 0, 0));
    send(reading(5, 15, 31, 31, 63, 63, 65535));
    send(reading(5, 1, 0, 0, 0, 0, 0));
    send(reading(5, 4, 31, 0, 0, 0, 0));
    send(reading(5, 1, 31, 0, 0, 0, 0));
    send(reading(7, 6, 15, 24, 0, 0, 0));
    send(reading(7, 6, 15, 31, 0, 0, 0));
    send(reading(7, 6, 15, 10, 60, 0, 0));
    send(reading(7, 6, 15, 10, 63, 0, 0));
    send(reading(7, 6, 15, 10, 20, 60, 0));
    send(reading(7, 6, 15, 10, 20, 63, 0));
    send(reading(7, 6, 15, 10, 20, 30, 256));
    send(reading(7, 6, 15, 10, 20, 30, 65535));
    wait_drained();

    program_prescaler(15'd0);
    send_subsecond_edges();
    send_random(120);
    wait_drained();

    program_prescaler(15'd32767);
    send_subsecond_edges();
    send_random(120);
    wait_drained();

    program_prescaler(15'd1);
    send_subsecond_edges();
    send_random(120);
    wait_drained();

    repeat (3) begin
      program_prescaler(15'($urandom));
      send_subsecond_edges();
      send_random(120);
      wait_drained();
    end

    // back-to-back stretch with neither side idling
    program_prescaler(15'($urandom_range(1023)));
    steady = 1'b1;
    send_random(200);
    wait_drained();
    steady = 1'b0;

    // write outside the register map must leave the prescaler alone
    apb_write(ADDR_UNMAPPED, $urandom);
    check_prescaler_readback();
    send_random(100);
    wait_drained();

    program_prescaler(PRESCALER_RESET);
    send_random(100);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_stamps.size() != 0)
      report_mismatch($sformatf("%0d conversions never completed", expected_stamps.size()));
    if (mismatch_count == 0)
      $display("tb_rtc_calendar_to_unix_time: clean");
    else
      $display("tb_rtc_calendar_to_unix_time: errors");
    $finish;
  end

endmodule
